// File: hw/rtl/xsc_pkg.sv
// ----------------------------------------------------------------------------
// xsc_pkg: shared types and constants of the XMODEM sender control
// Event codes passed from the classifier to the sequencer, phase codes,
// action and error codes, protocol characters and register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xsc_pkg;

  // Request kinds on the input stream
  localparam logic [2:0] REQ_BYTE  = 3'd0;
  localparam logic [2:0] REQ_TICK  = 3'd1;
  localparam logic [2:0] REQ_FRAME = 3'd2;
  localparam logic [2:0] REQ_EOF   = 3'd3;
  localparam logic [2:0] REQ_ABORT = 3'd4;

  // Protocol characters
  localparam logic [7:0] CH_ACK      = 8'h06;
  localparam logic [7:0] CH_NAK      = 8'h15;
  localparam logic [7:0] CH_CAN      = 8'h18;
  localparam logic [7:0] CH_SYNC_CRC = 8'h43;
  localparam logic [7:0] CH_SYNC_WX  = 8'h57;

  // Block payload sizes
  localparam logic [10:0] SMALL_BLOCK = 11'd128;
  localparam logic [10:0] BIG_BLOCK   = 11'd1024;

  // Register indexes and reset values
  localparam logic [1:0] REG_LONG_BLOCKS  = 2'd0;
  localparam logic [1:0] REG_SYNC_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_RESP_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_RETRY_LIMIT  = 2'd3;

  localparam logic [15:0] SYNC_TIMEOUT_RST = 16'd6000;
  localparam logic [15:0] RESP_TIMEOUT_RST = 16'd1000;
  localparam logic [3:0]  RETRY_LIMIT_RST  = 4'd3;

  // Action codes on the result stream
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_SEND   = 3'd1,
    ACT_RESEND = 3'd2,
    ACT_EOT    = 3'd3,
    ACT_CAN    = 3'd4,
    ACT_DONE   = 3'd5,
    ACT_FAIL   = 3'd6
  } action_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SYNC_TO   = 3'd1,
    ERR_WX_MODE   = 3'd2,
    ERR_RESP_TO   = 3'd3,
    ERR_REMOTE    = 3'd4,
    ERR_RETRIES   = 3'd5,
    ERR_EOT_ABORT = 3'd6
  } error_e;

  // Classified events
  typedef enum logic [3:0] {
    EV_NONE,
    EV_ACK,
    EV_NAK,
    EV_CAN,
    EV_SYNC_CRC,
    EV_SYNC_WX,
    EV_TICK,
    EV_FRAME,
    EV_EOF,
    EV_ABORT
  } event_e;

  typedef struct packed {
    event_e      kind;
    logic [10:0] frame_len;
  } event_t;

  // Sequencer phases, one-hot
  typedef enum logic [5:0] {
    PH_SYNC  = 6'b000001,
    PH_READY = 6'b000010,
    PH_RESP  = 6'b000100,
    PH_EOT   = 6'b001000,
    PH_DONE  = 6'b010000,
    PH_FAIL  = 6'b100000
  } phase_e;

  // Configuration bundle
  typedef struct packed {
    logic        long_blocks;
    logic [15:0] sync_timeout_ticks;
    logic [15:0] resp_timeout_ticks;
    logic [3:0]  retry_limit;
  } cfg_t;

endpackage

// File: hw/rtl/xsc_front.sv
// ----------------------------------------------------------------------------
// xsc_front: request classifier
// Turns a request word into a compact event: decodes the request kind and,
// for received bytes, which protocol character arrived.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xsc_front (
  input  logic [2:0]     req_type_i,
  input  logic [7:0]     rx_byte_i,
  input  logic [10:0]    frame_len_i,
  output xsc_pkg::event_t event_o
);

  xsc_pkg::event_e kind;

  // Decode request kind and received character
  always_comb begin
    kind = xsc_pkg::EV_NONE;
    case (req_type_i)
      xsc_pkg::REQ_BYTE: begin
        case (rx_byte_i)
          xsc_pkg::CH_ACK:      kind = xsc_pkg::EV_ACK;
          xsc_pkg::CH_NAK:      kind = xsc_pkg::EV_NAK;
          xsc_pkg::CH_CAN:      kind = xsc_pkg::EV_CAN;
          xsc_pkg::CH_SYNC_CRC: kind = xsc_pkg::EV_SYNC_CRC;
          xsc_pkg::CH_SYNC_WX:  kind = xsc_pkg::EV_SYNC_WX;
          default:              kind = xsc_pkg::EV_NONE;
        endcase
      end
      xsc_pkg::REQ_TICK:  kind = xsc_pkg::EV_TICK;
      xsc_pkg::REQ_FRAME: kind = xsc_pkg::EV_FRAME;
      xsc_pkg::REQ_EOF:   kind = xsc_pkg::EV_EOF;
      xsc_pkg::REQ_ABORT: kind = xsc_pkg::EV_ABORT;
      default:            kind = xsc_pkg::EV_NONE;
    endcase
  end

  assign event_o.kind      = kind;
  assign event_o.frame_len = frame_len_i;

endmodule

// File: hw/rtl/xsc_queue.sv
// ----------------------------------------------------------------------------
// xsc_queue: event queue
// Small first-in first-out buffer between classifier and sequencer.
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xsc_queue #(
  parameter int Width = 15,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/xsc_back.sv
// ----------------------------------------------------------------------------
// xsc_back: transfer sequencer
// Executes one event per cycle unless the result stalls, against the transfer
// state (phase, timers, retries, sequence number) and registers its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xsc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  xsc_pkg::cfg_t   cfg_i,
  input  xsc_pkg::event_t event_i,
  input  logic            event_valid_i,
  output logic            event_pop_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [2:0]      action_o,
  output logic [7:0]      frame_number_o,
  output logic [10:0]     block_bytes_o,
  output logic            big_block_o,
  output logic            use_crc_o,
  output logic [2:0]      error_code_o,
  output logic            ready_for_frame_o
);

  xsc_pkg::phase_e phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  tries_q, tries_d;
  logic [7:0]  seq_q, seq_d;
  logic        crc_q, crc_d;
  logic [10:0] len_q, len_d;
  logic        big_q, big_d;

  xsc_pkg::action_e act;
  xsc_pkg::error_e  err;
  logic [3:0]       limit;
  logic [10:0]      cap;
  logic             pop;

  logic        res_valid_q, res_valid_d;
  logic [2:0]  action_q;
  logic [7:0]  frame_number_q;
  logic [10:0] block_bytes_q;
  logic        big_block_q;
  logic        use_crc_q;
  logic [2:0]  error_code_q;
  logic        ready_q;

  // Take an event whenever the result register is free or draining
  assign pop         = event_valid_i && (!res_valid_q || res_ready_i);
  assign event_pop_o = pop;

  assign limit = (cfg_i.retry_limit == 4'd0) ? 4'd1 : cfg_i.retry_limit;
  assign cap   = cfg_i.long_blocks ? xsc_pkg::BIG_BLOCK : xsc_pkg::SMALL_BLOCK;

  // Next-state and result decision
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    tries_d = tries_q;
    seq_d   = seq_q;
    crc_d   = crc_q;
    len_d   = len_q;
    big_d   = big_q;
    act     = xsc_pkg::ACT_NONE;
    err     = xsc_pkg::ERR_NONE;
    if (pop) begin
      if (event_i.kind == xsc_pkg::EV_ABORT) begin
        if (phase_q != xsc_pkg::PH_DONE && phase_q != xsc_pkg::PH_FAIL) begin
          act     = xsc_pkg::ACT_CAN;
          err     = xsc_pkg::ERR_EOT_ABORT;
          phase_d = xsc_pkg::PH_FAIL;
        end
      end else begin
        case (phase_q)
          xsc_pkg::PH_SYNC: begin
            case (event_i.kind)
              xsc_pkg::EV_SYNC_CRC: begin
                crc_d   = 1'b1;
                phase_d = xsc_pkg::PH_READY;
              end
              xsc_pkg::EV_NAK: begin
                crc_d   = 1'b0;
                phase_d = xsc_pkg::PH_READY;
              end
              xsc_pkg::EV_SYNC_WX: begin
                act     = xsc_pkg::ACT_FAIL;
                err     = xsc_pkg::ERR_WX_MODE;
                phase_d = xsc_pkg::PH_FAIL;
              end
              xsc_pkg::EV_TICK: begin
                if (tick_q >= cfg_i.sync_timeout_ticks) begin
                  act     = xsc_pkg::ACT_FAIL;
                  err     = xsc_pkg::ERR_SYNC_TO;
                  phase_d = xsc_pkg::PH_FAIL;
                end else begin
                  tick_d = tick_q + 16'd1;
                end
              end
              default: ;
            endcase
          end
          xsc_pkg::PH_READY: begin
            case (event_i.kind)
              xsc_pkg::EV_FRAME: begin
                big_d   = cfg_i.long_blocks;
                len_d   = (event_i.frame_len < cap) ? event_i.frame_len : cap;
                tries_d = 4'd1;
                tick_d  = '0;
                act     = xsc_pkg::ACT_SEND;
                phase_d = xsc_pkg::PH_RESP;
              end
              xsc_pkg::EV_EOF: begin
                tick_d  = '0;
                act     = xsc_pkg::ACT_EOT;
                phase_d = xsc_pkg::PH_EOT;
              end
              default: ;
            endcase
          end
          xsc_pkg::PH_RESP: begin
            case (event_i.kind)
              xsc_pkg::EV_ACK: begin
                seq_d   = seq_q + 8'd1;
                phase_d = xsc_pkg::PH_READY;
              end
              xsc_pkg::EV_NAK: begin
                if (tries_q < limit) begin
                  tries_d = tries_q + 4'd1;
                  tick_d  = '0;
                  act     = xsc_pkg::ACT_RESEND;
                end else begin
                  act     = xsc_pkg::ACT_FAIL;
                  err     = xsc_pkg::ERR_RETRIES;
                  phase_d = xsc_pkg::PH_FAIL;
                end
              end
              xsc_pkg::EV_CAN: begin
                act     = xsc_pkg::ACT_FAIL;
                err     = xsc_pkg::ERR_REMOTE;
                phase_d = xsc_pkg::PH_FAIL;
              end
              xsc_pkg::EV_TICK: begin
                if (tick_q >= cfg_i.resp_timeout_ticks) begin
                  act     = xsc_pkg::ACT_FAIL;
                  err     = xsc_pkg::ERR_RESP_TO;
                  phase_d = xsc_pkg::PH_FAIL;
                end else begin
                  tick_d = tick_q + 16'd1;
                end
              end
              default: ;
            endcase
          end
          xsc_pkg::PH_EOT: begin
            case (event_i.kind)
              xsc_pkg::EV_ACK: begin
                act     = xsc_pkg::ACT_DONE;
                phase_d = xsc_pkg::PH_DONE;
              end
              xsc_pkg::EV_TICK: begin
                if (tick_q >= cfg_i.resp_timeout_ticks) begin
                  act     = xsc_pkg::ACT_FAIL;
                  err     = xsc_pkg::ERR_EOT_ABORT;
                  phase_d = xsc_pkg::PH_FAIL;
                end else begin
                  tick_d = tick_q + 16'd1;
                end
              end
              default: ;
            endcase
          end
          // done and failed are terminal
          default: ;
        endcase
      end
    end
  end

  // Transfer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= xsc_pkg::PH_SYNC;
      tick_q  <= '0;
      tries_q <= '0;
      seq_q   <= 8'd1;
      crc_q   <= 1'b1;
      len_q   <= '0;
      big_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      tries_q <= tries_d;
      seq_q   <= seq_d;
      crc_q   <= crc_d;
      len_q   <= len_d;
      big_q   <= big_d;
    end
  end

  // Result register
  assign res_valid_d = pop ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      action_q       <= act;
      frame_number_q <= seq_d;
      block_bytes_q  <= len_d;
      big_block_q    <= big_d;
      use_crc_q      <= crc_d;
      error_code_q   <= err;
      ready_q        <= (phase_d == xsc_pkg::PH_READY);
    end
  end

  assign res_valid_o       = res_valid_q;
  assign action_o          = action_q;
  assign frame_number_o    = frame_number_q;
  assign block_bytes_o     = block_bytes_q;
  assign big_block_o       = big_block_q;
  assign use_crc_o         = use_crc_q;
  assign error_code_o      = error_code_q;
  assign ready_for_frame_o = ready_q;

endmodule

// File: hw/rtl/xmodem_sender_control_top.sv
// ----------------------------------------------------------------------------
// xmodem_sender_control_top: XMODEM sender control
// Sequences the sending side of an XMODEM / XMODEM-1k transfer: sync,
// frame send and resend, EOT and cancel commands.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Content
// s_axis    in   tvalid/tready          tuser: req_type; tdata: rx_byte, frame_len
// m_axis    out  tvalid/tready          tuser: action; tdata: result fields
// cfg       in   cfg_we_i               cfg_idx_i selects register, cfg_wdata_i
//
// One word in per cycle while the queue has room, one result word out per
// input word. Each word is classified on entry, queued, and executed by the
// sequencer; its result appears on m_axis the cycle after it leaves the queue.
// The queue (QUEUE_DEPTH words) lets input continue while a result stalls.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xmodem_sender_control_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] rx_byte, [18:8] frame_len, zero pad
  input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] frame_number, [18:8] block_bytes,
                                     // [19] big_block, [20] use_crc,
                                     // [23:21] error_code, [24] ready_for_frame
  output logic [2:0]  m_axis_tuser,  // [2:0] action
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int EvW = $bits(xsc_pkg::event_t);

  xsc_pkg::cfg_t   cfg_q;
  xsc_pkg::event_t ev_in, ev_out;
  logic [EvW-1:0]  ev_out_bits;
  logic            q_full, q_empty, q_pop;

  logic [7:0]  frame_number;
  logic [10:0] block_bytes;
  logic        big_block, use_crc, ready_for_frame;
  logic [2:0]  error_code;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_blocks        <= 1'b0;
      cfg_q.sync_timeout_ticks <= xsc_pkg::SYNC_TIMEOUT_RST;
      cfg_q.resp_timeout_ticks <= xsc_pkg::RESP_TIMEOUT_RST;
      cfg_q.retry_limit        <= xsc_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        xsc_pkg::REG_LONG_BLOCKS:  cfg_q.long_blocks        <= cfg_wdata_i[0];
        xsc_pkg::REG_SYNC_TIMEOUT: cfg_q.sync_timeout_ticks <= cfg_wdata_i;
        xsc_pkg::REG_RESP_TIMEOUT: cfg_q.resp_timeout_ticks <= cfg_wdata_i;
        xsc_pkg::REG_RETRY_LIMIT:  cfg_q.retry_limit        <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Front: classify incoming words
  xsc_front u_front (
    .req_type_i  (s_axis_tuser),
    .rx_byte_i   (s_axis_tdata[7:0]),
    .frame_len_i (s_axis_tdata[18:8]),
    .event_o     (ev_in)
  );

  assign s_axis_tready = !q_full;

  // Event queue
  xsc_queue #(
    .Width (EvW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .wdata_i (ev_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (ev_out_bits),
    .empty_o (q_empty)
  );

  assign ev_out = xsc_pkg::event_t'(ev_out_bits);

  // Back: sequencer and result register
  xsc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .event_i           (ev_out),
    .event_valid_i     (!q_empty),
    .event_pop_o       (q_pop),
    .res_valid_o       (m_axis_tvalid),
    .res_ready_i       (m_axis_tready),
    .action_o          (m_axis_tuser),
    .frame_number_o    (frame_number),
    .block_bytes_o     (block_bytes),
    .big_block_o       (big_block),
    .use_crc_o         (use_crc),
    .error_code_o      (error_code),
    .ready_for_frame_o (ready_for_frame)
  );

  assign m_axis_tdata = {7'd0, ready_for_frame, error_code, use_crc, big_block,
                         block_bytes, frame_number};

endmodule

// File: sim/tb_xmodem_sender_control_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xmodem_sender_control_top: self-checking bench for the XMODEM sender
// Drives request words on the input stream. A behavioural model of the sender
// sequencing predicts one result word per request. Results are compared field
// by field in order. A short table of directed words covers sync, send, resend
// and misplaced requests. Random transfers with random idling on both sides
// follow, and the run closes with one randomly chosen way of ending the
// transfer.
// ----------------------------------------------------------------------------

module tb_xmodem_sender_control_top;

  // request types with no meaning to the block
  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

  typedef struct {
    xsc_pkg::action_e act;
    logic [7:0]       frame_no;
    logic [10:0]      payload;
    logic             big;
    logic             crc;
    xsc_pkg::error_e  err;
    logic             rdy;
  } xfer_res_t;

  typedef struct {
    logic [2:0]  req;
    logic [7:0]  rx;
    logic [10:0] len;
    bit          typed;
    xfer_res_t   res;
  } step_row_t;

  typedef enum int {
    END_DONE, END_EOT_TO, END_RESP_TO, END_REMOTE_CAN, END_RETRIES, END_ABORT
  } closing_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [2:0]  s_tuser = xsc_pkg::REQ_BYTE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = xsc_pkg::REG_LONG_BLOCKS;
  logic [15:0] cfg_wdata = '0;

  // model state and register copy
  xsc_pkg::cfg_t   regs_m;
  xsc_pkg::phase_e st_phase;
  logic [15:0]     st_ticks;
  logic [3:0]      st_tries;
  logic [7:0]      st_seq;
  logic            st_crc;
  logic [10:0]     st_len;
  logic            st_big;

  xfer_res_t   pending_q[$];
  xfer_res_t   spare_res;
  int          sent_items = 0;
  int          faults = 0;
  int          src_idle_pct = 38;
  int          sink_idle_pct = 85;
  int          holdoff_requests = 0;

  xmodem_sender_control_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // true when this tick ends the wait
  function automatic bit tick_expired(input logic [15:0] lim);
    if (st_ticks >= lim) return 1'b1;
    st_ticks = st_ticks + 16'd1;
    return 1'b0;
  endfunction

  function automatic logic [3:0] eff_retry_limit();
    return (regs_m.retry_limit == 4'd0) ? 4'd1 : regs_m.retry_limit;
  endfunction

  // next result of the sender sequencing for one request word
  function automatic xfer_res_t advance_sender(input logic [2:0] req,
                                               input logic [7:0] rx,
                                               input logic [10:0] len);
    xfer_res_t r;
    logic [10:0] cap;
    r.act = xsc_pkg::ACT_NONE;
    r.err = xsc_pkg::ERR_NONE;
    if (req == xsc_pkg::REQ_ABORT) begin
      if (st_phase != xsc_pkg::PH_DONE && st_phase != xsc_pkg::PH_FAIL) begin
        r.act = xsc_pkg::ACT_CAN;
        r.err = xsc_pkg::ERR_EOT_ABORT;
        st_phase = xsc_pkg::PH_FAIL;
      end
    end else begin
      case (st_phase)
        xsc_pkg::PH_SYNC: begin
          if (req == xsc_pkg::REQ_BYTE) begin
            if (rx == xsc_pkg::CH_SYNC_CRC || rx == xsc_pkg::CH_NAK) begin
              st_crc = (rx == xsc_pkg::CH_SYNC_CRC);
              st_phase = xsc_pkg::PH_READY;
            end else if (rx == xsc_pkg::CH_SYNC_WX) begin
              r.act = xsc_pkg::ACT_FAIL;
              r.err = xsc_pkg::ERR_WX_MODE;
              st_phase = xsc_pkg::PH_FAIL;
            end
          end else if (req == xsc_pkg::REQ_TICK) begin
            if (tick_expired(regs_m.sync_timeout_ticks)) begin
              r.act = xsc_pkg::ACT_FAIL;
              r.err = xsc_pkg::ERR_SYNC_TO;
              st_phase = xsc_pkg::PH_FAIL;
            end
          end
        end
        xsc_pkg::PH_READY: begin
          if (req == xsc_pkg::REQ_FRAME) begin
            st_big = regs_m.long_blocks;
            cap = st_big ? xsc_pkg::BIG_BLOCK : xsc_pkg::SMALL_BLOCK;
            st_len = (len < cap) ? len : cap;
            st_tries = 4'd1;
            st_ticks = '0;
            r.act = xsc_pkg::ACT_SEND;
            st_phase = xsc_pkg::PH_RESP;
          end else if (req == xsc_pkg::REQ_EOF) begin
            st_ticks = '0;
            r.act = xsc_pkg::ACT_EOT;
            st_phase = xsc_pkg::PH_EOT;
          end
        end
        xsc_pkg::PH_RESP: begin
          if (req == xsc_pkg::REQ_BYTE) begin
            if (rx == xsc_pkg::CH_ACK) begin
              st_seq = st_seq + 8'd1;
              st_phase = xsc_pkg::PH_READY;
            end else if (rx == xsc_pkg::CH_NAK) begin
              if (st_tries < eff_retry_limit()) begin
                st_tries = st_tries + 4'd1;
                st_ticks = '0;
                r.act = xsc_pkg::ACT_RESEND;
              end else begin
                r.act = xsc_pkg::ACT_FAIL;
                r.err = xsc_pkg::ERR_RETRIES;
                st_phase = xsc_pkg::PH_FAIL;
              end
            end else if (rx == xsc_pkg::CH_CAN) begin
              r.act = xsc_pkg::ACT_FAIL;
              r.err = xsc_pkg::ERR_REMOTE;
              st_phase = xsc_pkg::PH_FAIL;
            end
          end else if (req == xsc_pkg::REQ_TICK) begin
            if (tick_expired(regs_m.resp_timeout_ticks)) begin
              r.act = xsc_pkg::ACT_FAIL;
              r.err = xsc_pkg::ERR_RESP_TO;
              st_phase = xsc_pkg::PH_FAIL;
            end
          end
        end
        xsc_pkg::PH_EOT: begin
          // only ACK ends the wait, NAK and CAN are ignored here
          if (req == xsc_pkg::REQ_BYTE) begin
            if (rx == xsc_pkg::CH_ACK) begin
              r.act = xsc_pkg::ACT_DONE;
              st_phase = xsc_pkg::PH_DONE;
            end
          end else if (req == xsc_pkg::REQ_TICK) begin
            if (tick_expired(regs_m.resp_timeout_ticks)) begin
              r.act = xsc_pkg::ACT_FAIL;
              r.err = xsc_pkg::ERR_EOT_ABORT;
              st_phase = xsc_pkg::PH_FAIL;
            end
          end
        end
        default: ;
      endcase
    end
    r.frame_no = st_seq;
    r.payload = st_len;
    r.big = st_big;
    r.crc = st_crc;
    r.rdy = (st_phase == xsc_pkg::PH_READY);
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus

  function automatic step_row_t row(input logic [2:0] req, input logic [7:0] rx,
                                    input logic [10:0] len);
    step_row_t s;
    s.req = req;
    s.rx = rx;
    s.len = len;
    s.typed = 1'b0;
    return s;
  endfunction

  function automatic step_row_t row_exp(input logic [2:0] req, input logic [7:0] rx,
                                        input logic [10:0] len,
                                        input xsc_pkg::action_e act,
                                        input logic [7:0] fn, input logic [10:0] pl,
                                        input logic big, input logic crc,
                                        input xsc_pkg::error_e err, input logic rdy);
    step_row_t s;
    s = row(req, rx, len);
    s.typed = 1'b1;
    s.res.act = act;
    s.res.frame_no = fn;
    s.res.payload = pl;
    s.res.big = big;
    s.res.crc = crc;
    s.res.err = err;
    s.res.rdy = rdy;
    return s;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == xsc_pkg::CH_ACK || b == xsc_pkg::CH_NAK || b == xsc_pkg::CH_CAN);
    return b;
  endfunction

  function automatic logic [10:0] frame_size();
    case ($urandom_range(0, 3))
      0: return 11'($urandom_range(0, 2047));
      1: begin
        case ($urandom_range(0, 8))
          0: return 11'd0;
          1: return 11'd1;
          2: return 11'd127;
          3: return xsc_pkg::SMALL_BLOCK;
          4: return 11'd129;
          5: return 11'd1023;
          6: return xsc_pkg::BIG_BLOCK;
          7: return 11'd1025;
          default: return 11'd2047;
        endcase
      end
      default: return 11'($urandom_range(1, regs_m.long_blocks ? 1024 : 128));
    endcase
  endfunction

  // mid-transfer words: never one that ends the transfer
  task automatic pick_transfer_word(output logic [2:0] req, output logic [7:0] rx,
                                    output logic [10:0] len);
    int roll;
    roll = $urandom_range(0, 99);
    rx = 8'($urandom_range(0, 255));
    len = 11'($urandom_range(0, 2047));
    req = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
    case (st_phase)
      xsc_pkg::PH_READY: begin
        if (roll < 70) begin
          req = xsc_pkg::REQ_FRAME;
          len = frame_size();
        end else if (roll < 80) req = xsc_pkg::REQ_BYTE;
        else if (roll < 90) req = xsc_pkg::REQ_TICK;
      end
      xsc_pkg::PH_RESP: begin
        req = xsc_pkg::REQ_BYTE;
        rx = xsc_pkg::CH_ACK;
        if (roll < 45) ;
        else if (roll < 65) begin
          if (st_tries < eff_retry_limit()) rx = xsc_pkg::CH_NAK;
        end else if (roll < 80) begin
          if (st_ticks < regs_m.resp_timeout_ticks) req = xsc_pkg::REQ_TICK;
        end else if (roll < 90) rx = plain_byte();
        else if (roll < 95) begin
          req = $urandom_range(0, 1) ? xsc_pkg::REQ_FRAME : xsc_pkg::REQ_EOF;
        end
        else req = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
      end
      default: ;
    endcase
  endtask

  // words that steer the transfer to the chosen ending
  task automatic pick_closing_word(input closing_e how, output logic [2:0] req,
                                   output logic [7:0] rx, output logic [10:0] len);
    rx = 8'($urandom_range(0, 255));
    len = 11'($urandom_range(0, 2047));
    req = xsc_pkg::REQ_BYTE;
    if ($urandom_range(0, 4) == 0) begin
      req = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
    end else begin
      case (st_phase)
        xsc_pkg::PH_READY: begin
          if (how == END_DONE || how == END_EOT_TO) req = xsc_pkg::REQ_EOF;
          else if (how == END_ABORT) begin
            req = $urandom_range(0, 1) ? xsc_pkg::REQ_EOF : xsc_pkg::REQ_ABORT;
          end
          else req = xsc_pkg::REQ_FRAME;
        end
        xsc_pkg::PH_RESP: begin
          case (how)
            END_RESP_TO:    req = xsc_pkg::REQ_TICK;
            END_REMOTE_CAN: rx = xsc_pkg::CH_CAN;
            END_RETRIES:    rx = xsc_pkg::CH_NAK;
            END_ABORT:      req = xsc_pkg::REQ_ABORT;
            default:        rx = xsc_pkg::CH_ACK;
          endcase
        end
        xsc_pkg::PH_EOT: begin
          if (how == END_DONE) begin
            case ($urandom_range(0, 3))
              0: rx = xsc_pkg::CH_NAK;
              1: rx = xsc_pkg::CH_CAN;
              default: rx = xsc_pkg::CH_ACK;
            endcase
          end else if (how == END_ABORT) req = xsc_pkg::REQ_ABORT;
          else req = xsc_pkg::REQ_TICK;
        end
        default: rx = xsc_pkg::CH_SYNC_CRC;
      endcase
    end
  endtask

  // offer one word, predict its result once accepted
  task automatic send_word(input logic [2:0] req, input logic [7:0] rx,
                           input logic [10:0] len, input bit typed,
                           input xfer_res_t typed_res);
    xfer_res_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, len, rx};
    s_tuser <= req;
    do @(posedge clk); while (s_tready !== 1'b1);
    pred = advance_sender(req, rx, len);
    sent_items++;
    if (typed) pending_q.push_back(typed_res);
    else pending_q.push_back(pred);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    int guard;
    guard = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      xsc_pkg::REG_LONG_BLOCKS:  regs_m.long_blocks = val[0];
      xsc_pkg::REG_SYNC_TIMEOUT: regs_m.sync_timeout_ticks = val;
      xsc_pkg::REG_RESP_TIMEOUT: regs_m.resp_timeout_ticks = val;
      xsc_pkg::REG_RETRY_LIMIT:  regs_m.retry_limit = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_traffic(input int goal, input bit hold_off, input bit pause);
    int base;
    logic [2:0] req;
    logic [7:0] rx;
    logic [10:0] len;
    bit held;
    bit paused;
    base = sent_items;
    held = 1'b0;
    paused = 1'b0;
    while (sent_items - base < goal) begin
      if (hold_off && !held && sent_items - base >= goal / 3) begin
        holdoff_requests++;
        held = 1'b1;
      end
      if (pause && !paused && sent_items - base >= goal / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick_transfer_word(req, rx, len);
      send_word(req, rx, len, 1'b0, spare_res);
    end
  endtask

  // ------------------------------------------------------------ receiver

  // result-side ready, with a long hold-off on request
  always @(negedge clk) begin : sink_ready
    int hold_left;
    int holdoffs_seen;
    if (holdoff_requests != holdoffs_seen) begin
      holdoffs_seen = holdoff_requests;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // compare every accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    xfer_res_t want;
    if (rst_n && m_tvalid === 1'b1 && m_tready) begin
      if (pending_q.size() == 0) begin
        $error("result word with no prediction waiting, action %0d", m_tuser);
        faults++;
      end else begin
        want = pending_q.pop_front();
        if (m_tuser !== want.act) begin
          $error("action: expected %0d, got %0d", want.act, m_tuser);
          faults++;
        end
        if (m_tdata[7:0] !== want.frame_no) begin
          $error("frame_number: expected %0d, got %0d", want.frame_no, m_tdata[7:0]);
          faults++;
        end
        if (m_tdata[18:8] !== want.payload) begin
          $error("block_bytes: expected %0d, got %0d", want.payload, m_tdata[18:8]);
          faults++;
        end
        if (m_tdata[19] !== want.big) begin
          $error("big_block: expected %0d, got %0d", want.big, m_tdata[19]);
          faults++;
        end
        if (m_tdata[20] !== want.crc) begin
          $error("use_crc: expected %0d, got %0d", want.crc, m_tdata[20]);
          faults++;
        end
        if (m_tdata[23:21] !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, m_tdata[23:21]);
          faults++;
        end
        if (m_tdata[24] !== want.rdy) begin
          $error("ready_for_frame: expected %0d, got %0d", want.rdy, m_tdata[24]);
          faults++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main
  initial begin : main_seq
    step_row_t steps[25];
    logic sync_crc;
    logic [2:0] req;
    logic [7:0] rx;
    logic [10:0] len;
    closing_e how;

    // model state after reset
    regs_m.long_blocks = 1'b0;
    regs_m.sync_timeout_ticks = xsc_pkg::SYNC_TIMEOUT_RST;
    regs_m.resp_timeout_ticks = xsc_pkg::RESP_TIMEOUT_RST;
    regs_m.retry_limit = xsc_pkg::RETRY_LIMIT_RST;
    st_phase = xsc_pkg::PH_SYNC;
    st_ticks = '0;
    st_tries = '0;
    st_seq = 8'd1;
    st_crc = 1'b1;
    st_len = '0;
    st_big = 1'b0;

    // directed words; the sync character is 'C' or NAK by seed
    sync_crc = 1'($urandom_range(0, 1));
    steps[0]  = row_exp(xsc_pkg::REQ_TICK, 8'h00, 11'd0, xsc_pkg::ACT_NONE, 8'd1,
                        11'd0, 1'b0, 1'b1, xsc_pkg::ERR_NONE, 1'b0);
    steps[1]  = row_exp(xsc_pkg::REQ_BYTE, 8'h00, 11'd0, xsc_pkg::ACT_NONE, 8'd1,
                        11'd0, 1'b0, 1'b1, xsc_pkg::ERR_NONE, 1'b0);
    steps[2]  = row_exp(xsc_pkg::REQ_BYTE, 8'hFF, 11'd2047, xsc_pkg::ACT_NONE, 8'd1,
                        11'd0, 1'b0, 1'b1, xsc_pkg::ERR_NONE, 1'b0);
    // frame-ready and end of file before sync are ignored
    steps[3]  = row_exp(xsc_pkg::REQ_FRAME, 8'hFF, 11'd2047, xsc_pkg::ACT_NONE, 8'd1,
                        11'd0, 1'b0, 1'b1, xsc_pkg::ERR_NONE, 1'b0);
    steps[4]  = row_exp(xsc_pkg::REQ_EOF, 8'h00, 11'd0, xsc_pkg::ACT_NONE, 8'd1,
                        11'd0, 1'b0, 1'b1, xsc_pkg::ERR_NONE, 1'b0);
    steps[5]  = row_exp(REQ_UNKNOWN_HI, 8'hFF, 11'd2047, xsc_pkg::ACT_NONE, 8'd1,
                        11'd0, 1'b0, 1'b1, xsc_pkg::ERR_NONE, 1'b0);
    steps[6]  = row_exp(xsc_pkg::REQ_BYTE, xsc_pkg::CH_ACK, 11'd0, xsc_pkg::ACT_NONE,
                        8'd1, 11'd0, 1'b0, 1'b1, xsc_pkg::ERR_NONE, 1'b0);
    steps[7]  = row_exp(xsc_pkg::REQ_BYTE,
                        sync_crc ? xsc_pkg::CH_SYNC_CRC : xsc_pkg::CH_NAK, 11'd0,
                        xsc_pkg::ACT_NONE, 8'd1, 11'd0, 1'b0, sync_crc,
                        xsc_pkg::ERR_NONE, 1'b1);
    steps[8]  = row(xsc_pkg::REQ_TICK, 8'h00, 11'd0);
    steps[9]  = row(xsc_pkg::REQ_BYTE, 8'hAA, 11'd0);
    // empty frame still goes out
    steps[10] = row_exp(xsc_pkg::REQ_FRAME, 8'h5A, 11'd0, xsc_pkg::ACT_SEND, 8'd1,
                        11'd0, 1'b0, sync_crc, xsc_pkg::ERR_NONE, 1'b0);
    steps[11] = row(xsc_pkg::REQ_TICK, 8'h00, 11'd0);
    steps[12] = row_exp(xsc_pkg::REQ_BYTE, xsc_pkg::CH_NAK, 11'd0, xsc_pkg::ACT_RESEND,
                        8'd1, 11'd0, 1'b0, sync_crc, xsc_pkg::ERR_NONE, 1'b0);
    steps[13] = row(xsc_pkg::REQ_BYTE, xsc_pkg::CH_SYNC_CRC, 11'd0);
    steps[14] = row(xsc_pkg::REQ_FRAME, 8'h00, 11'd64);
    steps[15] = row(xsc_pkg::REQ_EOF, 8'h00, 11'd0);
    steps[16] = row_exp(xsc_pkg::REQ_BYTE, xsc_pkg::CH_ACK, 11'd0, xsc_pkg::ACT_NONE,
                        8'd2, 11'd0, 1'b0, sync_crc, xsc_pkg::ERR_NONE, 1'b1);
    // oversize frame clipped to the short block
    steps[17] = row_exp(xsc_pkg::REQ_FRAME, 8'h00, 11'd2047, xsc_pkg::ACT_SEND, 8'd2,
                        xsc_pkg::SMALL_BLOCK, 1'b0, sync_crc, xsc_pkg::ERR_NONE, 1'b0);
    steps[18] = row(xsc_pkg::REQ_BYTE, xsc_pkg::CH_NAK, 11'd0);
    steps[19] = row(xsc_pkg::REQ_BYTE, xsc_pkg::CH_NAK, 11'd0);
    steps[20] = row(xsc_pkg::REQ_BYTE, xsc_pkg::CH_ACK, 11'd0);
    steps[21] = row_exp(xsc_pkg::REQ_FRAME, 8'hFF, xsc_pkg::SMALL_BLOCK,
                        xsc_pkg::ACT_SEND, 8'd3, xsc_pkg::SMALL_BLOCK, 1'b0,
                        sync_crc, xsc_pkg::ERR_NONE, 1'b0);
    steps[22] = row(xsc_pkg::REQ_BYTE, xsc_pkg::CH_ACK, 11'd0);
    steps[23] = row(REQ_UNKNOWN_LO, 8'h00, 11'd0);
    steps[24] = row(REQ_UNKNOWN_HI, xsc_pkg::CH_NAK, 11'd1024);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) send_word(steps[i].req, steps[i].rx, steps[i].len,
                                 steps[i].typed, steps[i].res);
    drain_results();

    // sender idles often, receiver more
    set_reg(xsc_pkg::REG_LONG_BLOCKS, 16'd0);
    set_reg(xsc_pkg::REG_SYNC_TIMEOUT, 16'hFFFF);
    set_reg(xsc_pkg::REG_RESP_TIMEOUT, 16'($urandom_range(5, 40)));
    set_reg(xsc_pkg::REG_RETRY_LIMIT, 16'd15);
    src_idle_pct = 38;
    sink_idle_pct = 85;
    run_traffic(170, 1'b0, 1'b0);
    drain_results();

    // the other way round, long blocks, a zero retry limit acts as one
    set_reg(xsc_pkg::REG_LONG_BLOCKS, 16'd1);
    set_reg(xsc_pkg::REG_SYNC_TIMEOUT, 16'd0);
    set_reg(xsc_pkg::REG_RESP_TIMEOUT, 16'hFFFF);
    set_reg(xsc_pkg::REG_RETRY_LIMIT, 16'd0);
    src_idle_pct = 85;
    sink_idle_pct = 38;
    run_traffic(170, 1'b0, 1'b1);
    drain_results();

    // full rate with a long receiver hold-off
    set_reg(xsc_pkg::REG_LONG_BLOCKS, 16'($urandom_range(0, 1)));
    set_reg(xsc_pkg::REG_SYNC_TIMEOUT, 16'($urandom_range(0, 65535)));
    set_reg(xsc_pkg::REG_RESP_TIMEOUT, 16'd0);
    set_reg(xsc_pkg::REG_RETRY_LIMIT, 16'd1);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    run_traffic(160, 1'b1, 1'b0);
    drain_results();

    // close the transfer one way, then check the terminal state ignores all
    how = closing_e'($urandom_range(0, 5));
    set_reg(xsc_pkg::REG_LONG_BLOCKS, 16'($urandom_range(0, 1)));
    set_reg(xsc_pkg::REG_SYNC_TIMEOUT, 16'($urandom_range(0, 65535)));
    set_reg(xsc_pkg::REG_RESP_TIMEOUT, 16'($urandom_range(0, 12)));
    set_reg(xsc_pkg::REG_RETRY_LIMIT, 16'($urandom_range(0, 15)));
    src_idle_pct = 20;
    sink_idle_pct = 20;
    while (st_phase != xsc_pkg::PH_DONE && st_phase != xsc_pkg::PH_FAIL) begin
      pick_closing_word(how, req, rx, len);
      send_word(req, rx, len, 1'b0, spare_res);
    end
    repeat (12) begin
      send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                11'($urandom_range(0, 2047)), 1'b0, spare_res);
    end
    drain_results();
    repeat (8) @(posedge clk);

    if (pending_q.size() != 0)
      $error("%0d predicted result words never arrived", pending_q.size());
    if (faults == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/xsc_pkg.sv
hw/rtl/xsc_front.sv
hw/rtl/xsc_queue.sv
hw/rtl/xsc_back.sv
hw/rtl/xmodem_sender_control_top.sv
sim/tb_xmodem_sender_control_top.sv
